FILE: hdl/pct_pkg.sv
package pct_pkg;

    // default widths
    localparam int COORD_BITS_DEF = 32;
    localparam int ROT_BITS_DEF   = 20;

    // fixed register widths
    localparam int SHIFT_BITS     = 32;
    localparam int FOCAL_BITS     = 32;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_FOCAL   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW0    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW1    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW2    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHIFT_X = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHIFT_Y = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHIFT_Z = 3'd7;

    // unit focal length, Q16.16
    localparam logic [FOCAL_BITS-1:0] FOCAL_ONE = 32'h0001_0000;

    // transform actions
    typedef enum logic [2:0] {
        ACT_W2C      = 3'd0,
        ACT_C2W      = 3'd1,
        ACT_C2PIX    = 3'd2,
        ACT_PIX2C    = 3'd3,
        ACT_W2PIX    = 3'd4,
        ACT_PIX2W    = 3'd5,
        ACT_PIX2NORM = 3'd6,
        ACT_NONE     = 3'd7
    } action_t;

    function automatic int pct_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

FILE: hdl/pct_rot.sv
module pct_rot #(
    parameter int CB        = pct_pkg::COORD_BITS_DEF,
    parameter int RB        = pct_pkg::ROT_BITS_DEF,
    parameter bit TRANSPOSE = 1'b0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  pct_pkg::action_t       in_action,
    input  logic                   in_err,
    input  logic signed [CB-1:0]   in_a,
    input  logic signed [CB-1:0]   in_b,
    input  logic signed [CB-1:0]   in_c,
    input  logic [2:0][3*RB-1:0]   rows,
    input  logic [2:0][31:0]       shifts,
    output logic                   out_valid,
    output pct_pkg::action_t       out_action,
    output logic                   out_err,
    output logic signed [CB-1:0]   out_a,
    output logic signed [CB-1:0]   out_b,
    output logic signed [CB-1:0]   out_c
);
    import pct_pkg::*;

    localparam int MW = pct_max(CB, SHIFT_BITS) + 1;
    localparam int RF = RB - 2;
    localparam int PW = RB + MW;
    localparam int SW = PW + 2;
    localparam int HW = SW - RF + 1;
    localparam logic signed [SW-1:0] HALF = {{(SW-RF){1'b0}}, 1'b1, {(RF-1){1'b0}}};

    logic [2:0] vld_reg;

    // stage 0: optional translation removal
    logic signed [MW-1:0] q0_reg [3];
    logic signed [MW-1:0] q0_next [3];
    logic signed [CB-1:0] p0_reg [3];
    logic signed [CB-1:0] pin [3];
    action_t act0_reg;
    logic err0_reg;
    logic use0_reg;
    logic use0_next;

    // stage 1: nine products
    logic signed [PW-1:0] prod_reg [3][3];
    logic signed [PW-1:0] prod_next [3][3];
    logic signed [RB-1:0] rmat [3][3];
    logic signed [CB-1:0] p1_reg [3];
    action_t act1_reg;
    logic err1_reg;
    logic use1_reg;

    // stage 2: sum, round, translate, saturate
    logic signed [CB-1:0] res_reg [3];
    logic signed [CB-1:0] res_next [3];
    action_t act2_reg;
    logic err2_reg;

    function automatic logic signed [CB-1:0] sat(input logic signed [HW-1:0] x);
        logic [HW-CB:0] top;
        top = x[HW-1:CB-1];
        if (&top || ~|top)
            return x[CB-1:0];
        else if (x[HW-1])
            return {1'b1, {(CB-1){1'b0}}};
        else
            return {1'b0, {(CB-1){1'b1}}};
    endfunction

    assign pin[0] = in_a;
    assign pin[1] = in_b;
    assign pin[2] = in_c;

    // entry: decide use, subtract t for the inverse pose
    always_comb
    begin
        if (TRANSPOSE)
            use0_next = (in_action == ACT_C2W) || (in_action == ACT_PIX2W);
        else
            use0_next = (in_action == ACT_W2C) || (in_action == ACT_W2PIX);
        for (int k = 0; k < 3; k++)
        begin
            if (TRANSPOSE && use0_next)
                q0_next[k] = MW'(pin[k]) - MW'($signed(shifts[k]));
            else
                q0_next[k] = MW'(pin[k]);
        end
    end

    // rotation matrix, transposed for the inverse pose
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (TRANSPOSE)
                    rmat[i][j] = $signed(rows[j][(2-i)*RB +: RB]);
                else
                    rmat[i][j] = $signed(rows[i][(2-j)*RB +: RB]);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                prod_next[i][j] = rmat[i][j] * q0_reg[j];
    end

    always_comb
    begin
        logic signed [SW-1:0] acc;
        logic signed [SW-1:0] rnd;
        logic signed [HW-1:0] tot;
        for (int i = 0; i < 3; i++)
        begin
            acc = SW'(prod_reg[i][0]) + SW'(prod_reg[i][1]) + SW'(prod_reg[i][2]) + HALF;
            rnd = acc >>> RF;
            if (TRANSPOSE)
                tot = HW'(rnd);
            else
                tot = HW'(rnd) + HW'($signed(shifts[i]));
            res_next[i] = use1_reg ? sat(tot) : p1_reg[i];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], in_valid};
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                q0_reg[k]  <= q0_next[k];
                p0_reg[k]  <= pin[k];
                p1_reg[k]  <= p0_reg[k];
                res_reg[k] <= res_next[k];
                for (int j = 0; j < 3; j++)
                    prod_reg[k][j] <= prod_next[k][j];
            end
            act0_reg <= in_action;
            err0_reg <= in_err;
            use0_reg <= use0_next;
            act1_reg <= act0_reg;
            err1_reg <= err0_reg;
            use1_reg <= use0_reg;
            act2_reg <= act1_reg;
            err2_reg <= err1_reg;
        end
    end

    assign out_valid  = vld_reg[2];
    assign out_action = act2_reg;
    assign out_err    = err2_reg;
    assign out_a      = res_reg[0];
    assign out_b      = res_reg[1];
    assign out_c      = res_reg[2];

endmodule

FILE: hdl/pct_div.sv
module pct_div #(
    parameter int NW  = 81,
    parameter int DW  = 32,
    parameter int QN  = 34,
    parameter int SBW = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [1:0][NW-1:0]   in_num,
    input  logic [1:0][DW-1:0]   in_den,
    input  logic [SBW-1:0]       in_side,
    output logic                 out_valid,
    output logic [1:0][QN-1:0]   out_quo,
    output logic [SBW-1:0]       out_side
);
    import pct_pkg::*;

    localparam int CW = pct_max(NW - QN, DW);

    logic [QN:0]             vld_reg;
    logic [1:0][DW-1:0]      rem_reg  [QN+1];
    logic [1:0][QN-1:0]      low_reg  [QN+1];
    logic [1:0][QN-1:0]      quo_reg  [QN+1];
    logic [1:0][DW-1:0]      den_reg  [QN+1];
    logic [SBW-1:0]          side_reg [QN+1];

    logic [1:0][DW-1:0]      rem0_next;
    logic [1:0][QN-1:0]      quo0_next;

    // entry: quotients that do not fit QN bits clamp to all ones
    always_comb
    begin
        logic [NW-QN-1:0] hi;
        logic             ovf;
        for (int k = 0; k < 2; k++)
        begin
            hi  = in_num[k][NW-1:QN];
            ovf = CW'(hi) >= CW'(in_den[k]);
            rem0_next[k] = ovf ? '0 : DW'(hi);
            quo0_next[k] = ovf ? '1 : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[QN-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem0_next;
            quo_reg[0]  <= quo0_next;
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
            for (int k = 0; k < 2; k++)
                low_reg[0][k] <= in_num[k][QN-1:0];
        end
    end

    // one restoring step per stage, most significant quotient bit first
    for (genvar s = 1; s <= QN; s++)
    begin : g_step
        logic [1:0][DW-1:0] rem_next;
        logic [1:0][QN-1:0] quo_next;
        logic [1:0][QN-1:0] low_next;

        always_comb
        begin
            logic [DW:0] t;
            logic        ge;
            for (int k = 0; k < 2; k++)
            begin
                t  = {rem_reg[s-1][k], low_reg[s-1][k][QN-1]};
                ge = t >= {1'b0, den_reg[s-1][k]};
                rem_next[k] = ge ? DW'(t - {1'b0, den_reg[s-1][k]}) : t[DW-1:0];
                quo_next[k] = quo_reg[s-1][k] | (ge ? (QN'(1) << (QN - s)) : '0);
                low_next[k] = low_reg[s-1][k] << 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                quo_reg[s]  <= quo_next;
                low_reg[s]  <= low_next;
                den_reg[s]  <= den_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_valid = vld_reg[QN];
    assign out_quo   = quo_reg[QN];
    assign out_side  = side_reg[QN];

endmodule

FILE: hdl/pct_proj.sv
module pct_proj #(
    parameter int CB = pct_pkg::COORD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  pct_pkg::action_t       in_action,
    input  logic                   in_err,
    input  logic signed [CB-1:0]   in_a,
    input  logic signed [CB-1:0]   in_b,
    input  logic signed [CB-1:0]   in_c,
    input  logic [63:0]            focal_pair,
    input  logic [63:0]            center_pair,
    output logic                   out_valid,
    output pct_pkg::action_t       out_action,
    output logic                   out_err,
    output logic signed [CB-1:0]   out_a,
    output logic signed [CB-1:0]   out_b,
    output logic signed [CB-1:0]   out_c
);
    import pct_pkg::*;

    localparam int AW  = pct_max(CB, 32) + 1;
    localparam int BW  = pct_max(CB, 18);
    localparam int NW  = AW + BW;
    localparam int DW  = pct_max(CB, 32);
    localparam int DSW = DW + 1;
    localparam int QN  = pct_max(CB, 32) + 2;
    localparam int TW  = QN + 2;
    localparam int SBW = 3 + 1 + 2 + 3 * CB;
    localparam logic signed [BW-1:0] NORM_ONE = BW'(32'sd65536);

    logic [2:0] vld_reg;
    logic       vld3_reg;

    logic signed [CB-1:0] pin [2];
    logic [FOCAL_BITS-1:0] fk [2];
    logic signed [31:0]    ck [2];

    // stage 0: operands
    logic signed [AW-1:0]  a_reg  [2];
    logic signed [AW-1:0]  a_next [2];
    logic signed [BW-1:0]  b_reg  [2];
    logic signed [BW-1:0]  b_next [2];
    logic signed [DSW-1:0] d0_reg  [2];
    logic signed [DSW-1:0] d0_next [2];
    action_t act0_reg;
    logic err0_reg;
    logic err0_next;
    logic signed [CB-1:0] p0_reg [3];

    // stage 1: products
    logic signed [NW-1:0]  prod_reg [2];
    logic signed [DSW-1:0] d1_reg   [2];
    action_t act1_reg;
    logic err1_reg;
    logic signed [CB-1:0] p1_reg [3];

    // stage 2: magnitudes
    logic [1:0][NW-1:0] num_reg;
    logic [1:0][NW-1:0] num_next;
    logic [1:0][DW-1:0] den_reg;
    logic [1:0][DW-1:0] den_next;
    logic [1:0]         neg_reg;
    logic [1:0]         neg_next;
    action_t act2_reg;
    logic err2_reg;
    logic signed [CB-1:0] p2_reg [3];

    // divider
    logic               dv_valid;
    logic [1:0][QN-1:0] dv_quo;
    logic [SBW-1:0]     dv_side;

    // stage 3: sign, center, saturate
    action_t act_d;
    logic err_d;
    logic [1:0] neg_d;
    logic signed [CB-1:0] pd [3];
    logic signed [CB-1:0] res_reg  [3];
    logic signed [CB-1:0] res_next [3];
    action_t act3_reg;
    logic err3_reg;

    function automatic logic signed [CB-1:0] sat(input logic signed [TW-1:0] x);
        logic [TW-CB:0] top;
        top = x[TW-1:CB-1];
        if (&top || ~|top)
            return x[CB-1:0];
        else if (x[TW-1])
            return {1'b1, {(CB-1){1'b0}}};
        else
            return {1'b0, {(CB-1){1'b1}}};
    endfunction

    assign pin[0] = in_a;
    assign pin[1] = in_b;
    assign fk[0]  = focal_pair[63:32];
    assign fk[1]  = focal_pair[31:0];
    assign ck[0]  = $signed(center_pair[63:32]);
    assign ck[1]  = $signed(center_pair[31:0]);

    // operand selection per action
    always_comb
    begin
        logic to_pix;
        logic from_pix;
        logic signed [AW-1:0] diff;
        to_pix   = (in_action == ACT_C2PIX) || (in_action == ACT_W2PIX);
        from_pix = (in_action == ACT_PIX2C) || (in_action == ACT_PIX2W);
        err0_next = in_err;
        if (to_pix && (in_c == '0))
            err0_next = 1'b1;
        if ((from_pix || (in_action == ACT_PIX2NORM)) && ((fk[0] == '0) || (fk[1] == '0)))
            err0_next = 1'b1;
        for (int k = 0; k < 2; k++)
        begin
            diff = AW'(pin[k]) - AW'(ck[k]);
            if (to_pix)
            begin
                a_next[k]  = AW'($signed({1'b0, fk[k]}));
                b_next[k]  = BW'(pin[k]);
                d0_next[k] = DSW'(in_c);
            end
            else if (from_pix)
            begin
                a_next[k]  = diff;
                b_next[k]  = BW'(in_c);
                d0_next[k] = DSW'($signed({1'b0, fk[k]}));
            end
            else
            begin
                a_next[k]  = diff;
                b_next[k]  = NORM_ONE;
                d0_next[k] = DSW'($signed({1'b0, fk[k]}));
            end
        end
    end

    // sign and magnitude ahead of the divider
    always_comb
    begin
        logic signed [DSW-1:0] dm;
        for (int k = 0; k < 2; k++)
        begin
            neg_next[k] = prod_reg[k][NW-1] ^ d1_reg[k][DSW-1];
            num_next[k] = prod_reg[k][NW-1] ? NW'(-prod_reg[k]) : prod_reg[k];
            dm          = d1_reg[k][DSW-1] ? -d1_reg[k] : d1_reg[k];
            den_next[k] = dm[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg  <= {vld_reg[1:0], in_valid};
            vld3_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 2; k++)
            begin
                a_reg[k]    <= a_next[k];
                b_reg[k]    <= b_next[k];
                d0_reg[k]   <= d0_next[k];
                prod_reg[k] <= a_reg[k] * b_reg[k];
                d1_reg[k]   <= d0_reg[k];
            end
            num_reg  <= num_next;
            den_reg  <= den_next;
            neg_reg  <= neg_next;
            p0_reg[0] <= in_a;
            p0_reg[1] <= in_b;
            p0_reg[2] <= in_c;
            for (int k = 0; k < 3; k++)
            begin
                p1_reg[k]  <= p0_reg[k];
                p2_reg[k]  <= p1_reg[k];
                res_reg[k] <= res_next[k];
            end
            act0_reg <= in_action;
            err0_reg <= err0_next;
            act1_reg <= act0_reg;
            err1_reg <= err0_reg;
            act2_reg <= act1_reg;
            err2_reg <= err1_reg;
            act3_reg <= act_d;
            err3_reg <= err_d;
        end
    end

    pct_div #(
        .NW  (NW),
        .DW  (DW),
        .QN  (QN),
        .SBW (SBW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_reg[2]),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .in_side   ({act2_reg, err2_reg, neg_reg, p2_reg[0], p2_reg[1], p2_reg[2]}),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    assign act_d = action_t'(dv_side[SBW-1 -: 3]);
    assign err_d = dv_side[SBW-4];
    assign neg_d = dv_side[SBW-5 -: 2];
    assign pd[0] = dv_side[3*CB-1 -: CB];
    assign pd[1] = dv_side[2*CB-1 -: CB];
    assign pd[2] = dv_side[CB-1:0];

    // final sign, center offset and saturation
    always_comb
    begin
        logic to_pix;
        logic from_pix;
        logic signed [QN:0]   q;
        logic signed [TW-1:0] tot;
        logic signed [CB-1:0] s [2];
        to_pix   = (act_d == ACT_C2PIX) || (act_d == ACT_W2PIX);
        from_pix = (act_d == ACT_PIX2C) || (act_d == ACT_PIX2W);
        for (int k = 0; k < 2; k++)
        begin
            q   = {1'b0, dv_quo[k]};
            q   = neg_d[k] ? -q : q;
            tot = TW'(q) + (to_pix ? TW'(ck[k]) : TW'(0));
            s[k] = sat(tot);
        end
        if (to_pix || from_pix || (act_d == ACT_PIX2NORM))
        begin
            res_next[0] = s[0];
            res_next[1] = s[1];
            res_next[2] = from_pix ? pd[2] : '0;
        end
        else
        begin
            res_next[0] = pd[0];
            res_next[1] = pd[1];
            res_next[2] = pd[2];
        end
    end

    assign out_valid  = vld3_reg;
    assign out_action = act3_reg;
    assign out_err    = err3_reg;
    assign out_a      = res_reg[0];
    assign out_b      = res_reg[1];
    assign out_c      = res_reg[2];

endmodule

FILE: hdl/pinhole_camera_transform_top.sv
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------
// input     | in_valid / in_stall  | action, coord_a, coord_b, coord_c
// output    | out_valid / out_stall| result_a, result_b, result_c, divide_error
// config    | cfg_write            | cfg_index, cfg_data
//
// one transaction per cycle unless stalled; data passes the forward rotation,
// the projection with its one-bit-per-stage divider, the inverse rotation and
// the output register; the whole pipeline advances together and holds only
// when the output register is full and out_stall is high
// reset clears valid bits and loads identity pose, unit focal, zero center
module pinhole_camera_transform_top #(
    parameter int COORD_BITS = pct_pkg::COORD_BITS_DEF,
    parameter int ROT_BITS   = pct_pkg::ROT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [2:0]                          action,
    input  logic signed [COORD_BITS-1:0]        coord_a,
    input  logic signed [COORD_BITS-1:0]        coord_b,
    input  logic signed [COORD_BITS-1:0]        coord_c,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [COORD_BITS-1:0]        result_a,
    output logic signed [COORD_BITS-1:0]        result_b,
    output logic signed [COORD_BITS-1:0]        result_c,
    output logic                                divide_error,
    input  logic                                cfg_write,
    input  logic [pct_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pct_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import pct_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int RB = ROT_BITS;
    localparam int RF = RB - 2;
    localparam logic [3*RB-1:0] ROW0_RST = (3*RB)'(1) << (2*RB + RF);
    localparam logic [3*RB-1:0] ROW1_RST = (3*RB)'(1) << (RB + RF);
    localparam logic [3*RB-1:0] ROW2_RST = (3*RB)'(1) << RF;

    logic en;

    // configuration registers
    logic [63:0]           focal_reg;
    logic [63:0]           center_reg;
    logic [2:0][3*RB-1:0]  row_reg;
    logic [2:0][31:0]      shift_reg;

    // stage links
    logic               r1_valid;
    action_t            r1_action;
    logic               r1_err;
    logic signed [CB-1:0] r1_a, r1_b, r1_c;
    logic               pj_valid;
    action_t            pj_action;
    logic               pj_err;
    logic signed [CB-1:0] pj_a, pj_b, pj_c;
    logic               r2_valid;
    action_t            r2_action;
    logic               r2_err;
    logic signed [CB-1:0] r2_a, r2_b, r2_c;

    // output register
    logic               out_valid_reg;
    logic               out_err_reg;
    action_t            out_act_reg;
    logic signed [CB-1:0] res_reg [3];
    logic signed [CB-1:0] res_next [3];
    logic               zero_out;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg  <= {FOCAL_ONE, FOCAL_ONE};
            center_reg <= '0;
            row_reg[0] <= ROW0_RST;
            row_reg[1] <= ROW1_RST;
            row_reg[2] <= ROW2_RST;
            shift_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FOCAL:   focal_reg    <= cfg_data;
                REG_CENTER:  center_reg   <= cfg_data;
                REG_ROW0:    row_reg[0]   <= cfg_data[3*RB-1:0];
                REG_ROW1:    row_reg[1]   <= cfg_data[3*RB-1:0];
                REG_ROW2:    row_reg[2]   <= cfg_data[3*RB-1:0];
                REG_SHIFT_X: shift_reg[0] <= cfg_data[31:0];
                REG_SHIFT_Y: shift_reg[1] <= cfg_data[31:0];
                REG_SHIFT_Z: shift_reg[2] <= cfg_data[31:0];
                default:     ;
            endcase
        end
    end

    // world to camera
    pct_rot #(
        .CB        (CB),
        .RB        (RB),
        .TRANSPOSE (1'b0)
    ) u_rot_fwd (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .in_action  (action_t'(action)),
        .in_err     (1'b0),
        .in_a       (coord_a),
        .in_b       (coord_b),
        .in_c       (coord_c),
        .rows       (row_reg),
        .shifts     (shift_reg),
        .out_valid  (r1_valid),
        .out_action (r1_action),
        .out_err    (r1_err),
        .out_a      (r1_a),
        .out_b      (r1_b),
        .out_c      (r1_c)
    );

    // projection and back-projection
    pct_proj #(
        .CB (CB)
    ) u_proj (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (r1_valid),
        .in_action   (r1_action),
        .in_err      (r1_err),
        .in_a        (r1_a),
        .in_b        (r1_b),
        .in_c        (r1_c),
        .focal_pair  (focal_reg),
        .center_pair (center_reg),
        .out_valid   (pj_valid),
        .out_action  (pj_action),
        .out_err     (pj_err),
        .out_a       (pj_a),
        .out_b       (pj_b),
        .out_c       (pj_c)
    );

    // camera to world
    pct_rot #(
        .CB        (CB),
        .RB        (RB),
        .TRANSPOSE (1'b1)
    ) u_rot_inv (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (pj_valid),
        .in_action  (pj_action),
        .in_err     (pj_err),
        .in_a       (pj_a),
        .in_b       (pj_b),
        .in_c       (pj_c),
        .rows       (row_reg),
        .shifts     (shift_reg),
        .out_valid  (r2_valid),
        .out_action (r2_action),
        .out_err    (r2_err),
        .out_a      (r2_a),
        .out_b      (r2_b),
        .out_c      (r2_c)
    );

    // errors and the unused action give an all-zero point
    assign zero_out    = r2_err || (r2_action == ACT_NONE);
    assign res_next[0] = zero_out ? '0 : r2_a;
    assign res_next[1] = zero_out ? '0 : r2_b;
    assign res_next[2] = zero_out ? '0 : r2_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= r2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
                res_reg[k] <= res_next[k];
            out_err_reg <= r2_err;
            out_act_reg <= r2_action;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_a     = res_reg[0];
    assign result_b     = res_reg[1];
    assign result_c     = res_reg[2];
    assign divide_error = out_err_reg;

    // checks
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_error |-> result_a == '0 && result_b == '0 && result_c == '0)
        else $error("error result carries a nonzero point");

    a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is free");

    a_none_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_act_reg == ACT_NONE |-> !divide_error)
        else $error("unused action flagged a divide error");

endmodule

FILE: sim/pct_checker.sv
module pct_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [2:0]                          action,
    input  logic signed [31:0]                  coord_a,
    input  logic signed [31:0]                  coord_b,
    input  logic signed [31:0]                  coord_c,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [31:0]                  result_a,
    input  logic signed [31:0]                  result_b,
    input  logic signed [31:0]                  result_c,
    input  logic                                divide_error,
    input  logic                                cfg_write,
    input  logic [pct_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pct_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import pct_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic               err;
    } point_t;

    // shadow copy of the camera registers
    logic [63:0] focal_pair;
    logic [63:0] center_pair;
    logic [59:0] rot_row [3];
    logic signed [31:0] shift_v [3];

    point_t projected_q [$];

    function automatic wide_t clamp32(wide_t v);
        wide_t hi;
        wide_t lo;
        hi = 32'sh7fffffff;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic wide_t rot_entry(int i, int j);
        logic signed [19:0] e;
        wide_t w;
        e = rot_row[i][(2-j)*20 +: 20];
        w = e;
        return w;
    endfunction

    function automatic wide_t focal_of(int k);
        wide_t w;
        w = 0;
        w[31:0] = (k == 0) ? focal_pair[63:32] : focal_pair[31:0];
        return w;
    endfunction

    function automatic wide_t center_of(int k);
        logic signed [31:0] c;
        wide_t w;
        c = (k == 0) ? center_pair[63:32] : center_pair[31:0];
        w = c;
        return w;
    endfunction

    function automatic wide_t shift_of(int i);
        wide_t w;
        w = shift_v[i];
        return w;
    endfunction

    // rotate then translate, round half up on the rotation sum
    function automatic wide_t cam_axis(int i, wide_t x, wide_t y, wide_t z);
        wide_t acc;
        acc = rot_entry(i, 0) * x + rot_entry(i, 1) * y + rot_entry(i, 2) * z;
        acc = (acc + (128'sd1 <<< 17)) >>> 18;
        return clamp32(acc + shift_of(i));
    endfunction

    // untranslate exactly, then apply the transposed rotation
    function automatic wide_t world_axis(int i, wide_t x, wide_t y, wide_t z);
        wide_t acc;
        acc = rot_entry(0, i) * (x - shift_of(0)) + rot_entry(1, i) * (y - shift_of(1))
            + rot_entry(2, i) * (z - shift_of(2));
        acc = (acc + (128'sd1 <<< 17)) >>> 18;
        return clamp32(acc);
    endfunction

    function automatic wide_t pix_axis(int k, wide_t pk, wide_t z);
        return clamp32((focal_of(k) * pk) / z + center_of(k));
    endfunction

    function automatic wide_t unpix_axis(int k, wide_t pk, wide_t d);
        return clamp32(((pk - center_of(k)) * d) / focal_of(k));
    endfunction

    function automatic point_t project(logic [2:0] act, logic signed [31:0] ia,
                                       logic signed [31:0] ib, logic signed [31:0] ic);
        wide_t x, y, z, mx, my, mz, rx, ry, rz;
        logic ok;
        logic focal_ok;
        point_t e;
        x = ia;
        y = ib;
        z = ic;
        rx = 0;
        ry = 0;
        rz = 0;
        ok = 1'b1;
        focal_ok = (focal_pair[63:32] != 0) && (focal_pair[31:0] != 0);
        case (action_t'(act))
            ACT_W2C:
            begin
                rx = cam_axis(0, x, y, z);
                ry = cam_axis(1, x, y, z);
                rz = cam_axis(2, x, y, z);
            end
            ACT_C2W:
            begin
                rx = world_axis(0, x, y, z);
                ry = world_axis(1, x, y, z);
                rz = world_axis(2, x, y, z);
            end
            ACT_C2PIX:
            begin
                ok = (z != 0);
                if (ok)
                begin
                    rx = pix_axis(0, x, z);
                    ry = pix_axis(1, y, z);
                end
            end
            ACT_PIX2C:
            begin
                ok = focal_ok;
                if (ok)
                begin
                    rx = unpix_axis(0, x, z);
                    ry = unpix_axis(1, y, z);
                    rz = z;
                end
            end
            ACT_W2PIX:
            begin
                mx = cam_axis(0, x, y, z);
                my = cam_axis(1, x, y, z);
                mz = cam_axis(2, x, y, z);
                ok = (mz != 0);
                if (ok)
                begin
                    rx = pix_axis(0, mx, mz);
                    ry = pix_axis(1, my, mz);
                end
            end
            ACT_PIX2W:
            begin
                ok = focal_ok;
                if (ok)
                begin
                    mx = unpix_axis(0, x, z);
                    my = unpix_axis(1, y, z);
                    mz = z;
                    rx = world_axis(0, mx, my, mz);
                    ry = world_axis(1, mx, my, mz);
                    rz = world_axis(2, mx, my, mz);
                end
            end
            ACT_PIX2NORM:
            begin
                ok = focal_ok;
                if (ok)
                begin
                    rx = unpix_axis(0, x, 128'sd65536);
                    ry = unpix_axis(1, y, 128'sd65536);
                end
            end
            default: ;
        endcase
        if (!ok)
        begin
            rx = 0;
            ry = 0;
            rz = 0;
        end
        e.a = rx[31:0];
        e.b = ry[31:0];
        e.c = rz[31:0];
        e.err = !ok;
        return e;
    endfunction

    // watch all three ports at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        point_t exp_p;
        if (!rst_n)
        begin
            focal_pair  = {FOCAL_ONE, FOCAL_ONE};
            center_pair = '0;
            rot_row[0]  = 60'd1 << 58;
            rot_row[1]  = 60'd1 << 38;
            rot_row[2]  = 60'd1 << 18;
            shift_v[0]  = '0;
            shift_v[1]  = '0;
            shift_v[2]  = '0;
            projected_q.delete();
            fail_count  = 0;
            pending     = 0;
            checked     = 0;
        end
        else
        begin
            // input transaction
            if (in_valid && !in_stall)
                projected_q.push_back(project(action, coord_a, coord_b, coord_c));

            // output transaction
            if (out_valid && !out_stall)
            begin
                checked++;
                if (projected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h %h %h err=%b",
                                 result_a, result_b, result_c, divide_error);
                end
                else
                begin
                    exp_p = projected_q.pop_front();
                    if (exp_p.a !== result_a || exp_p.b !== result_b ||
                        exp_p.c !== result_c || exp_p.err !== divide_error)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp %h %h %h err=%b, got %h %h %h err=%b",
                                     exp_p.a, exp_p.b, exp_p.c, exp_p.err,
                                     result_a, result_b, result_c, divide_error);
                    end
                end
            end

            // register write
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FOCAL:   focal_pair  = cfg_data;
                    REG_CENTER:  center_pair = cfg_data;
                    REG_ROW0:    rot_row[0]  = cfg_data[59:0];
                    REG_ROW1:    rot_row[1]  = cfg_data[59:0];
                    REG_ROW2:    rot_row[2]  = cfg_data[59:0];
                    REG_SHIFT_X: shift_v[0]  = cfg_data[31:0];
                    REG_SHIFT_Y: shift_v[1]  = cfg_data[31:0];
                    REG_SHIFT_Z: shift_v[2]  = cfg_data[31:0];
                    default: ;
                endcase
            end
            pending = projected_q.size();
        end
    end

endmodule

FILE: sim/tb_pinhole_camera_transform_top.sv
module tb_pinhole_camera_transform_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pct_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int HOLD_CYCLES    = 400;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [2:0] action;
    logic signed [31:0] coord_a;
    logic signed [31:0] coord_b;
    logic signed [31:0] coord_c;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] result_a;
    logic signed [31:0] result_b;
    logic signed [31:0] result_c;
    logic divide_error;
    logic cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    int fail_count;
    int pending;
    int checked;
    int points_sent;
    bit hold_req;
    bit hold_served;

    pinhole_camera_transform_top dut (.*);

    pct_checker u_checker (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int run_left;
        int mode;
        run_left = 0;
        mode = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_served)
            begin
                hold_served = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (run_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    run_left = $urandom_range(5, 60);
                end
                run_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 9) < 3);
                    default: out_stall <= ($urandom_range(0, 9) < 8);
                endcase
            end
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired, %0d results still pending", pending);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_point(input action_t act, input logic [31:0] a,
                              input logic [31:0] b, input logic [31:0] c);
        in_valid <= 1'b1;
        action   <= act;
        coord_a  <= a;
        coord_b  <= b;
        coord_c  <= c;
        do @(posedge clk); while (in_stall);
        points_sent++;
    endtask

    task automatic pause_sender(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // stop offering, wait for every result, then let the pipe settle
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // the caller drops cfg_write after the last write of a sequence
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [63:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return 32'h0;
            3, 4:    return $urandom;
            default: return $urandom_range(0, 400 << 16) - (200 << 16);
        endcase
    endfunction

    function automatic logic [19:0] pick_rot(input int style);
        case (style)
            0:       return 20'($urandom_range(0, 1 << 19) - (1 << 18));
            1:       return 20'h80000;
            2:       return 20'h7ffff;
            default: return 20'($urandom);
        endcase
    endfunction

    task automatic load_camera(input int setting);
        logic [63:0] f, c;
        logic [31:0] tx, ty, tz;
        int style;
        case (setting)
            1:
            begin
                f  = {32'($urandom_range(100, 900) << 16), 32'($urandom_range(100, 900) << 16)};
                c  = {32'(320 << 16), 32'(240 << 16)};
                tx = $urandom_range(0, 20 << 16) - (10 << 16);
                ty = $urandom_range(0, 20 << 16) - (10 << 16);
                tz = $urandom_range(0, 20 << 16);
                style = 0;
            end
            2:
            begin
                f  = 64'hffffffff_ffffffff;
                c  = 64'h80000000_7fffffff;
                tx = 32'h7fffffff;
                ty = 32'h80000000;
                tz = 32'h7fffffff;
                style = 1;
            end
            3:
            begin
                f  = {32'h0, 32'($urandom)};
                c  = {32'($urandom), 32'($urandom)};
                tx = $urandom;
                ty = $urandom;
                tz = $urandom;
                style = 3;
            end
            4:
            begin
                f  = {32'($urandom), 32'($urandom)};
                c  = {32'($urandom), 32'($urandom)};
                tx = $urandom;
                ty = $urandom;
                tz = $urandom;
                style = 3;
            end
            default:
            begin
                f  = {32'h1, 32'h0};
                c  = 64'h0;
                tx = 32'h0;
                ty = 32'h0;
                tz = 32'h0;
                style = 2;
            end
        endcase
        write_reg(REG_FOCAL, f);
        write_reg(REG_CENTER, c);
        write_reg(REG_ROW0, {4'hf, pick_rot(style), pick_rot(style), pick_rot(style)});
        write_reg(REG_ROW1, {4'h0, pick_rot(style), pick_rot(style), pick_rot(style)});
        write_reg(REG_ROW2, {4'ha, pick_rot(style), pick_rot(style), pick_rot(style)});
        write_reg(REG_SHIFT_X, {32'hffffffff, tx});
        write_reg(REG_SHIFT_Y, {32'h0, ty});
        write_reg(REG_SHIFT_Z, {32'h0, tz});
        cfg_write <= 1'b0;
    endtask

    // bursts of random points with random gaps
    task automatic random_points(input int count);
        int burst;
        logic [31:0] depth;
        while (count > 0)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && count > 0)
            begin
                depth = ($urandom_range(0, 7) == 0) ? 32'h0 : pick_coord();
                send_point(action_t'($urandom_range(0, 7)), pick_coord(), pick_coord(), depth);
                burst--;
                count--;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 8));
        end
    endtask

    // stimulus
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = ACT_W2C;
        coord_a   = '0;
        coord_b   = '0;
        coord_c   = '0;
        cfg_write = 1'b0;
        cfg_index = REG_FOCAL;
        cfg_data  = '0;
        hold_req  = 1'b0;
        hold_served = 1'b0;
        points_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed points on the reset pose
        send_point(ACT_W2C, 32'h7fffffff, 32'h80000000, 32'h00010000);
        send_point(ACT_W2C, 32'h80000000, 32'h7fffffff, 32'hffffffff);
        send_point(ACT_C2W, 32'h00030000, 32'hfffe8000, 32'h00050000);
        send_point(ACT_C2PIX, 32'h00020000, 32'h00040000, 32'h00020000);
        send_point(ACT_C2PIX, 32'h00020000, 32'h00040000, 32'h0);
        send_point(ACT_C2PIX, 32'h7fffffff, 32'h80000000, 32'h00000001);
        send_point(ACT_PIX2C, 32'h00100000, 32'hfff00000, 32'h0);
        send_point(ACT_PIX2C, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_point(ACT_W2PIX, 32'h00010000, 32'h00010000, 32'h0);
        send_point(ACT_W2PIX, 32'hffff0000, 32'h00020000, 32'h00040000);
        send_point(ACT_PIX2W, 32'h00050000, 32'h00060000, 32'h00020000);
        send_point(ACT_PIX2W, 32'h80000000, 32'h80000000, 32'h80000000);
        send_point(ACT_PIX2NORM, 32'h7fffffff, 32'h80000000, 32'h12345678);
        send_point(ACT_PIX2NORM, 32'h00008000, 32'hffff8000, 32'h0);
        send_point(ACT_NONE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        drain();

        // zero focal length on one axis, every action
        load_camera(5);
        for (int i = 0; i < 8; i++)
            send_point(action_t'(i), 32'h00010000, 32'hffff0000, 32'h00020000);
        drain();

        // several camera settings, the sender keeps pushing through one long hold-off
        for (int setting = 1; setting <= 5; setting++)
        begin
            load_camera(setting);
            if (setting == 1)
                hold_req = 1'b1;
            random_points(150);
            drain();
        end

        $display("sent %0d points over reset, typical, extreme, zero-focal and random cameras",
                 points_sent);
        $display("checked %0d results, %0d failures", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
